FILE: rtl/core/olist_pkg.sv
// Shared types and codes for the ordered list engine.
package olist_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT     = 3'd4,
    OP_SEARCH     = 3'd5
  } olist_op_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_BADPOS   = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_NOTFOUND = 3'd4
  } olist_status_e;

  // What every cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_OPEN   = 2'd1,
    CELL_CLOSE  = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } olist_state_e;

  localparam int unsigned OpWidth    = 3;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned PosWidth   = 5;
  localparam int unsigned StatWidth  = 3;
  localparam int unsigned IdxWidth   = 5;
  localparam int unsigned LenWidth   = 5;

  localparam logic [IdxWidth-1:0] NoIndex = '1;

endpackage

FILE: rtl/core/olist_if.sv
// Handshake channels for the list engine: request and response.
interface olist_in_if import olist_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic [OpWidth-1:0]            opcode;
  logic signed [ValueWidth-1:0]  value;
  logic [PosWidth-1:0]           position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

interface olist_out_if import olist_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic [StatWidth-1:0]        status;
  logic signed [IdxWidth-1:0]  found_index;
  logic [LenWidth-1:0]         length;

  modport source (output valid, output status, output found_index, output length, input ready);
  modport sink   (input valid, input status, input found_index, input length, output ready);
endinterface

FILE: rtl/core/olist_cell.sv
// One storage cell of the list: holds an entry and takes it from a neighbor.
module olist_cell import olist_pkg::*; #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned INDEX      = 0,
  localparam int unsigned IW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  cell_op_e              op_i,
  input  logic [IW-1:0]         at_i,
  input  logic [IW-1:0]         last_i,
  input  logic [DATA_WIDTH-1:0] word_i,
  input  logic [DATA_WIDTH-1:0] prev_i,
  input  logic [DATA_WIDTH-1:0] next_i,
  input  logic [DATA_WIDTH-1:0] head_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  localparam logic [IW-1:0] MyIdx = IW'(INDEX);

  logic [DATA_WIDTH-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    case (op_i)
      CELL_OPEN: begin
        if (MyIdx == at_i) begin
          data_d = word_i;
        end else if (MyIdx > at_i) begin
          data_d = prev_i;
        end
      end
      CELL_CLOSE: data_d = next_i;
      // head wraps around to the last occupied cell
      CELL_ROTATE: begin
        if (MyIdx == last_i) begin
          data_d = head_i;
        end else if (MyIdx < last_i) begin
          data_d = next_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: rtl/core/ordered_list_engine_core.sv
// Top level of the ordered list engine: cell row, control and result register.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+--------------------------------------
//   req_i   | in  | valid / ready | opcode, value, position
//   rsp_o   | out | valid / ready | status, found_index, length
//
// Push, pop front and insert shift the cells from the given place on; pop back only
// shortens the list. Search rotates the occupied cells as a ring past cell 0, one entry
// compared per cycle, ending in their original order; an empty list is not scanned.
// One item is in work at a time; the next is taken once the result register is free
// or being emptied. Reset clears the length and the control state only.
module ordered_list_engine_core import olist_pkg::*; #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  olist_in_if.sink     req_i,
  olist_out_if.source  rsp_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > PosWidth) ? CW : PosWidth;
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  olist_state_e state_d, state_q;
  logic [CW-1:0] count_d, count_q;
  logic [IW-1:0] step_d, step_q;
  logic [IW-1:0] hit_idx_d, hit_idx_q;
  logic          hit_d, hit_q;
  logic [DATA_WIDTH-1:0] key_d, key_q;

  logic                 out_valid_d, out_valid_q;
  logic [StatWidth-1:0] out_stat_d, out_stat_q;
  logic [IdxWidth-1:0]  out_idx_d, out_idx_q;
  logic [LenWidth-1:0]  out_len_d, out_len_q;

  cell_op_e              cell_op;
  logic [IW-1:0]         cell_at;
  logic [IW-1:0]         last_idx;
  logic [DATA_WIDTH-1:0] word;
  logic [63:0]           value_ext;
  logic [PW-1:0]         pos_ext, cnt_ext;
  logic                  accept, head_match;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  assign req_i.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign value_ext = 64'(req_i.value);
  assign word      = value_ext[DATA_WIDTH-1:0];
  assign pos_ext   = PW'(req_i.position);
  assign cnt_ext   = PW'(count_q);
  assign last_idx  = IW'(count_q - CW'(1));
  assign head_match = (cell_data[0] == key_q);

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev, next;
    if (g == 0) begin : g_first
      assign prev = word;
    end else begin : g_prev
      assign prev = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next = cell_data[g];
    end else begin : g_next
      assign next = cell_data[g+1];
    end
    olist_cell #(
      .DEPTH     (DEPTH),
      .DATA_WIDTH(DATA_WIDTH),
      .INDEX     (g)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (cell_op),
      .at_i   (cell_at),
      .last_i (last_idx),
      .word_i (word),
      .prev_i (prev),
      .next_i (next),
      .head_i (cell_data[0]),
      .data_o (cell_data[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_stat_d  = out_stat_q;
    out_idx_d   = out_idx_q;
    out_len_d   = out_len_q;
    cell_op     = CELL_HOLD;
    cell_at     = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          out_stat_d  = STAT_OK;
          out_idx_d   = NoIndex;
          case (req_i.opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (count_q == Full) begin
                out_stat_d = STAT_FULL;
              end else begin
                cell_op = CELL_OPEN;
                cell_at = (req_i.opcode == OP_PUSH_FRONT) ? '0 : IW'(count_q);
                count_d = count_q + CW'(1);
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (count_q == '0) begin
                out_stat_d = STAT_EMPTY;
              end else begin
                if (req_i.opcode == OP_POP_FRONT) begin
                  cell_op = CELL_CLOSE;
                end
                count_d = count_q - CW'(1);
              end
            end
            OP_INSERT: begin
              if (pos_ext > cnt_ext) begin
                out_stat_d = STAT_BADPOS;
              end else if (count_q == Full) begin
                out_stat_d = STAT_FULL;
              end else begin
                cell_op = CELL_OPEN;
                cell_at = IW'(pos_ext);
                count_d = count_q + CW'(1);
              end
            end
            OP_SEARCH: begin
              if (count_q == '0) begin
                out_stat_d = STAT_NOTFOUND;
              end else begin
                // result comes at the end of the scan
                out_valid_d = 1'b0;
                state_d     = ST_SEARCH;
                key_d       = word;
                step_d      = '0;
                hit_d       = 1'b0;
              end
            end
            default: ;
          endcase
          out_len_d = LenWidth'(count_d);
        end
      end
      ST_SEARCH: begin
        cell_op = CELL_ROTATE;
        if (head_match && !hit_q) begin
          hit_d     = 1'b1;
          hit_idx_d = step_q;
        end
        step_d = step_q + IW'(1);
        if (step_q == last_idx) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_stat_d  = hit_d ? STAT_OK : STAT_NOTFOUND;
          out_idx_d   = hit_d ? IdxWidth'(hit_idx_d) : NoIndex;
          out_len_d   = LenWidth'(count_q);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q     <= step_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    key_q      <= key_d;
    out_stat_q <= out_stat_d;
    out_idx_q  <= out_idx_d;
    out_len_q  <= out_len_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_stat_q;
  assign rsp_o.found_index = out_idx_q;
  assign rsp_o.length      = out_len_q;

endmodule

FILE: rtl/core/olist_chk.sv
// Port-level checks for the list engine, bound to the top level.
module olist_chk import olist_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [StatWidth-1:0] status_i,
  input logic [IdxWidth-1:0]  found_index_i,
  input logic [LenWidth-1:0]  length_i
);

  localparam logic [LenWidth-1:0] FullLen = LenWidth'(DEPTH);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(length_i))
    else $error("result changed while stalled");

  a_no_take_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("item taken while result is stalled");

  a_index_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (found_index_i != NoIndex) |-> status_i == STAT_OK)
    else $error("index given on a failed operation");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == STAT_FULL) |-> length_i == FullLen)
    else $error("full status with list not full");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == STAT_EMPTY) |-> length_i == '0)
    else $error("empty status with entries held");

endmodule

bind ordered_list_engine_core olist_chk #(.DEPTH(DEPTH)) u_olist_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .status_i     (rsp_o.status),
  .found_index_i(rsp_o.found_index),
  .length_i     (rsp_o.length)
);
